// File: src/ppu_rsu_pkg.sv
// Shared types and codes for the register and scroll unit.
// No dependencies; imported by ppu_rsu_next and the top level.
`timescale 1ns / 1ps
`default_nettype none

package ppu_rsu_pkg;

   // transaction function codes
   localparam logic [3:0] FUNC_REG_READ     = 4'd0;
   localparam logic [3:0] FUNC_REG_WRITE    = 4'd1;
   localparam logic [3:0] FUNC_INC_X        = 4'd2;
   localparam logic [3:0] FUNC_INC_Y        = 4'd3;
   localparam logic [3:0] FUNC_COPY_X       = 4'd4;
   localparam logic [3:0] FUNC_COPY_Y       = 4'd5;
   localparam logic [3:0] FUNC_VBLANK_START = 4'd6;
   localparam logic [3:0] FUNC_FRAME_START  = 4'd7;
   localparam logic [3:0] FUNC_SPRITE_FLAGS = 4'd8;
   localparam logic [3:0] FUNC_NMI_ACK      = 4'd9;

   // bus register numbers
   localparam logic [2:0] REG_CTRL   = 3'd0;
   localparam logic [2:0] REG_MASK   = 3'd1;
   localparam logic [2:0] REG_STATUS = 3'd2;
   localparam logic [2:0] REG_SCROLL = 3'd5;
   localparam logic [2:0] REG_ADDR   = 3'd6;
   localparam logic [2:0] REG_DATA   = 3'd7;

   localparam logic [13:0] PALETTE_BASE = 14'h3F00;
   localparam logic [15:0] ROW_STRIDE   = 16'd32;
   localparam logic [15:0] COPY_X_MASK  = 16'h041F;
   localparam logic [15:0] COPY_Y_MASK  = 16'h7BE0;

   typedef struct packed {
      logic [7:0]  control;
      logic [7:0]  mask;
      logic [2:0]  status;   // bit0 overflow, bit1 sprite zero hit, bit2 vblank
      logic [15:0] cur;
      logic [15:0] tmp;
      logic [2:0]  fine_x;
      logic        toggle;
      logic [7:0]  rbuf;
      logic        nmi;
   } state_type;

   typedef struct packed {
      logic [7:0]  read_data;
      logic [13:0] mem_addr;
      logic        mem_read;
      logic        mem_write;
      logic [7:0]  mem_wdata;
   } access_type;

endpackage

`default_nettype wire

// File: src/ppu_rsu_next.sv
// Next-state and bus-access logic for one transaction (purely combinational).
// Depends on ppu_rsu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ppu_rsu_next
   import ppu_rsu_pkg::*;
(
   input  state_type   state,
   input  logic [3:0]  func,
   input  logic [2:0]  reg_select,
   input  logic [7:0]  write_byte,
   input  logic [7:0]  mem_rdata,
   output state_type   state_nxt,
   output access_type  access
);

   logic        render_on;
   logic [15:0] port_step;
   logic [15:0] port_next;
   logic [15:0] bump_x;
   logic [15:0] bump_y;
   logic [4:0]  row_next;
   logic        nt_y;
   logic [15:0] tmp_addr_lo;

   assign render_on = state.mask[3] | state.mask[4];
   assign port_step = state.control[2] ? ROW_STRIDE : 16'd1;
   assign port_next = state.cur + port_step;
   assign tmp_addr_lo = {state.tmp[15:8], write_byte};

   // coarse x wraps into the neighbouring nametable
   always_comb begin
      if (state.cur[4:0] == 5'd31) begin
         bump_x = {state.cur[15:11], ~state.cur[10], state.cur[9:5], 5'd0};
      end else begin
         bump_x = state.cur + 16'd1;
      end
   end

   // row 29 is the last visible row: wrap and flip nametable; row 31 wraps without the flip
   always_comb begin
      row_next = state.cur[9:5];
      nt_y     = state.cur[11];
      if (state.cur[9:5] == 5'd29) begin
         row_next = 5'd0;
         nt_y     = ~state.cur[11];
      end else if (state.cur[9:5] == 5'd31) begin
         row_next = 5'd0;
      end else begin
         row_next = state.cur[9:5] + 5'd1;
      end
      if (state.cur[14:12] != 3'd7) begin
         bump_y = {state.cur[15], state.cur[14:12] + 3'd1, state.cur[11:0]};
      end else begin
         bump_y = {state.cur[15], 3'd0, nt_y, state.cur[10], row_next, state.cur[4:0]};
      end
   end

   always_comb begin
      state_nxt = state;
      access    = '0;
      case (func)
         FUNC_REG_READ: begin
            if (reg_select == REG_STATUS) begin
               access.read_data = {state.status, state.rbuf[4:0]};
               state_nxt.status = {1'b0, state.status[1:0]};
               state_nxt.toggle = 1'b0;
            end else if (reg_select == REG_DATA) begin
               access.mem_addr  = state.cur[13:0];
               access.mem_read  = 1'b1;
               // palette reads bypass the buffer
               access.read_data = (state.cur[13:0] >= PALETTE_BASE) ? mem_rdata : state.rbuf;
               state_nxt.rbuf   = mem_rdata;
               state_nxt.cur    = port_next;
            end
         end
         FUNC_REG_WRITE: begin
            unique case (reg_select)
               REG_CTRL: begin
                  state_nxt.control    = write_byte;
                  state_nxt.tmp[11:10] = write_byte[1:0];
               end
               REG_MASK: begin
                  state_nxt.mask = write_byte;
               end
               REG_SCROLL: begin
                  if (!state.toggle) begin
                     state_nxt.fine_x   = write_byte[2:0];
                     state_nxt.tmp[4:0] = write_byte[7:3];
                  end else begin
                     state_nxt.tmp[14:12] = write_byte[2:0];
                     state_nxt.tmp[9:5]   = write_byte[7:3];
                  end
                  state_nxt.toggle = ~state.toggle;
               end
               REG_ADDR: begin
                  if (!state.toggle) begin
                     state_nxt.tmp = {2'b00, write_byte[5:0], state.tmp[7:0]};
                  end else begin
                     state_nxt.tmp = tmp_addr_lo;
                     state_nxt.cur = tmp_addr_lo;
                  end
                  state_nxt.toggle = ~state.toggle;
               end
               REG_DATA: begin
                  access.mem_addr  = state.cur[13:0];
                  access.mem_write = 1'b1;
                  access.mem_wdata = write_byte;
                  state_nxt.cur    = port_next;
               end
               default: begin
               end
            endcase
         end
         FUNC_INC_X: begin
            if (render_on) state_nxt.cur = bump_x;
         end
         FUNC_INC_Y: begin
            if (render_on) state_nxt.cur = bump_y;
         end
         FUNC_COPY_X: begin
            if (render_on) begin
               state_nxt.cur = (state.cur & ~COPY_X_MASK) | (state.tmp & COPY_X_MASK);
            end
         end
         FUNC_COPY_Y: begin
            if (render_on) begin
               state_nxt.cur = (state.cur & ~COPY_Y_MASK) | (state.tmp & COPY_Y_MASK);
            end
         end
         FUNC_VBLANK_START: begin
            state_nxt.status[2] = 1'b1;
            if (state.control[7]) state_nxt.nmi = 1'b1;
         end
         FUNC_FRAME_START: begin
            state_nxt.status = 3'd0;
         end
         FUNC_SPRITE_FLAGS: begin
            state_nxt.status[1:0] = state.status[1:0] | write_byte[1:0];
         end
         FUNC_NMI_ACK: begin
            state_nxt.nmi = 1'b0;
         end
         default: begin
         end
      endcase
   end

endmodule

`default_nettype wire

// File: src/ppu_register_and_scroll_unit_core.sv
// Top level of the register and scroll unit: state registers, result register, handshake.
// Depends on ppu_rsu_pkg and ppu_rsu_next.
//
//   port group   dir   role
//   req_*        in    bus access or render-timing event, one per transaction
//   rsp_*        out   read data, memory request and updated scroll/register state
//
// One transaction per cycle unless a held result stalls on rsp_ready; a result appears the cycle after acceptance.
// The state update and result are computed in a single pass into the result register.
// req_ready is low only while a result is held and rsp_ready is low.
// Synchronous reset clears the state registers to zero and drops rsp_valid; the result register is not reset.
`timescale 1ns / 1ps
`default_nettype none

module ppu_register_and_scroll_unit_core
   import ppu_rsu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [3:0]  req_func,
   input  logic [2:0]  req_reg_select,
   input  logic [7:0]  req_write_byte,
   input  logic [7:0]  req_mem_rdata,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_read_data,
   output logic [13:0] rsp_mem_addr,
   output logic        rsp_mem_read,
   output logic        rsp_mem_write,
   output logic [7:0]  rsp_mem_wdata,
   output logic [15:0] rsp_cur_addr,
   output logic [2:0]  rsp_fine_scroll_x,
   output logic        rsp_nmi_pending,
   output logic [7:0]  rsp_control_out,
   output logic [7:0]  rsp_mask_out
);

   state_type  state_ff;
   state_type  state_in;
   access_type access_in;
   access_type access_ff;
   state_type  view_ff;    // state snapshot shown with the result
   logic       rsp_valid_ff;
   logic       accept;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   ppu_rsu_next u_next (
      .state      (state_ff),
      .func       (req_func),
      .reg_select (req_reg_select),
      .write_byte (req_write_byte),
      .mem_rdata  (req_mem_rdata),
      .state_nxt  (state_in),
      .access     (access_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         state_ff     <= state_in;
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         access_ff <= access_in;
         view_ff   <= state_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_read_data     = access_ff.read_data;
   assign rsp_mem_addr      = access_ff.mem_addr;
   assign rsp_mem_read      = access_ff.mem_read;
   assign rsp_mem_write     = access_ff.mem_write;
   assign rsp_mem_wdata     = access_ff.mem_wdata;
   assign rsp_cur_addr      = view_ff.cur;
   assign rsp_fine_scroll_x = view_ff.fine_x;
   assign rsp_nmi_pending   = view_ff.nmi;
   assign rsp_control_out   = view_ff.control;
   assign rsp_mask_out      = view_ff.mask;

   a_reset_clears_valid : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid set after reset");

   a_data_write_strobe : assert property (@(posedge clock) disable iff (reset)
      (accept && req_func == FUNC_REG_WRITE && req_reg_select == REG_DATA)
         |=> (rsp_valid && rsp_mem_write && !rsp_mem_read))
      else $error("data-port write did not raise mem_write");

   a_nmi_ack_clears : assert property (@(posedge clock) disable iff (reset)
      (accept && req_func == FUNC_NMI_ACK) |=> (rsp_valid && !rsp_nmi_pending))
      else $error("nmi still pending after acknowledge");

   a_state_matches_view : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_cur_addr == state_ff.cur && rsp_nmi_pending == state_ff.nmi))
      else $error("shown state differs from held state");

endmodule

`default_nettype wire
